### design/bvp_pkg.sv
// ----------------------------------------------------------------------------
// bvp_pkg
// Shared constants and types for the battery voltage to percent converter.
// ----------------------------------------------------------------------------
package bvp_pkg;

  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned MV_W     = 13;
  localparam int unsigned PCT_W    = 7;
  localparam int unsigned INDEX_W  = 2;

  // Scaling: battery_mv = floor(sample * ADC_FULL_MV / ADC_FULL_CODE) * 2.
  localparam int unsigned PROD_W        = 24;
  localparam int unsigned ADC_FULL_MV   = 3300;
  localparam int unsigned ADC_FULL_CODE = 4095;
  // Reciprocal of 4095 scaled by 2^24; the estimate is low by at most one.
  localparam int unsigned RECIP_MUL     = 4097;
  localparam int unsigned RECIP_SHIFT   = 24;
  localparam int unsigned QUOT_W        = 12;

  localparam logic [MV_W-1:0] MV_MAX = MV_W'(4200);
  localparam logic [MV_W-1:0] MV_MIN = MV_W'(3000);

  // Register indexes on the configuration port.
  localparam logic [INDEX_W-1:0] REG_CHARGE_THRESHOLD = 2'd0;
  localparam logic [INDEX_W-1:0] REG_LOW_PERCENT      = 2'd1;
  localparam logic [INDEX_W-1:0] REG_CRITICAL_PERCENT = 2'd2;

  localparam logic [MV_W-1:0]  RESET_CHARGE_THRESHOLD = MV_W'(4100);
  localparam logic [PCT_W-1:0] RESET_LOW_PERCENT      = PCT_W'(15);
  localparam logic [PCT_W-1:0] RESET_CRITICAL_PERCENT = PCT_W'(5);

  // Interpolation segments, lowest first. Segment 0 spans 300 mV, the rest 100 mV.
  localparam int unsigned SEGS    = 10;
  localparam int unsigned DELTA_W = 9;
  localparam int unsigned RISE_W  = 4;
  localparam int unsigned IPROD_W = 11;
  localparam int unsigned FRAC_W  = 5;

  typedef logic [MV_W-1:0]   seg_mv_t  [SEGS];
  typedef logic [PCT_W-1:0]  seg_pct_t [SEGS];
  typedef logic [RISE_W-1:0] seg_rise_t[SEGS];

  localparam seg_mv_t SEG_LO = '{
    13'd3000, 13'd3300, 13'd3400, 13'd3500, 13'd3600,
    13'd3700, 13'd3800, 13'd3900, 13'd4000, 13'd4100
  };
  localparam seg_pct_t SEG_PCT = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd35, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90
  };
  localparam seg_rise_t SEG_RISE = '{
    4'd5, 4'd5, 4'd10, 4'd15, 4'd15, 4'd10, 4'd10, 4'd10, 4'd10, 4'd10
  };

  // Division of the interpolation product by the span: x * m >> 17, exact for x <= 1500.
  localparam int unsigned DIV_SHIFT = 17;
  localparam int unsigned DIV_M_W   = 11;
  localparam logic [DIV_M_W-1:0] DIV_M_100 = DIV_M_W'(1311);
  localparam logic [DIV_M_W-1:0] DIV_M_300 = DIV_M_W'(437);

endpackage

### design/bvp_scale.sv
// ----------------------------------------------------------------------------
// bvp_scale
// Three-stage pipeline from a converter sample to clamped battery millivolts.
// ----------------------------------------------------------------------------
module bvp_scale import bvp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [SAMPLE_W-1:0] sample,
  output logic                out_valid,
  output logic [MV_W-1:0]     mv
);

  logic                     s1_valid;
  logic [PROD_W-1:0]        s1_prod;
  logic                     s2_valid;
  logic [PROD_W-1:0]        s2_prod;
  logic [QUOT_W-1:0]        s2_quot;
  logic [PROD_W+MV_W-1:0]   recip_prod;
  logic [PROD_W-1:0]        quot_back;
  logic [PROD_W-1:0]        rem;
  logic [QUOT_W-1:0]        quot;
  logic [MV_W-1:0]          mv_raw;
  logic [MV_W-1:0]          mv_next;

  assign recip_prod = (PROD_W+MV_W)'(s1_prod) * (PROD_W+MV_W)'(RECIP_MUL);

  // The reciprocal estimate is at most one short; one compare fixes it.
  assign quot_back = (PROD_W'(s2_quot) << 12) - PROD_W'(s2_quot);
  assign rem       = s2_prod - quot_back;
  assign quot      = (rem >= PROD_W'(ADC_FULL_CODE)) ? s2_quot + 1'b1 : s2_quot;
  assign mv_raw    = {quot, 1'b0};

  always_comb begin
    mv_next = mv_raw;
    if (mv_raw > MV_MAX) begin
      mv_next = MV_MAX;
    end else if (mv_raw < MV_MIN) begin
      mv_next = MV_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
    s1_prod <= PROD_W'(sample) * PROD_W'(ADC_FULL_MV);
    s2_prod <= s1_prod;
    s2_quot <= recip_prod[RECIP_SHIFT +: QUOT_W];
    mv      <= mv_next;
  end

endmodule

### design/bvp_interp.sv
// ----------------------------------------------------------------------------
// bvp_interp
// Two-stage pipeline from millivolts to interpolated state of charge.
// ----------------------------------------------------------------------------
module bvp_interp import bvp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [MV_W-1:0]  mv,
  output logic             out_valid,
  output logic [MV_W-1:0]  mv_out,
  output logic [PCT_W-1:0] pct
);

  logic                 s1_valid;
  logic [MV_W-1:0]      s1_mv;
  logic [PCT_W-1:0]     s1_base;
  logic [IPROD_W-1:0]   s1_prod;
  logic                 s1_wide;
  logic [PCT_W-1:0]     base_next;
  logic [RISE_W-1:0]    rise_sel;
  logic [MV_W-1:0]      lo_sel;
  logic                 wide_next;
  logic [DELTA_W-1:0]   delta;
  logic [DIV_M_W-1:0]   div_m;
  logic [IPROD_W+DIV_M_W-1:0] div_prod;

  // Pick the highest segment whose low point does not exceed the voltage.
  // The top segment also covers 4200 mV exactly, which lands on 100.
  always_comb begin
    lo_sel    = SEG_LO[0];
    base_next = SEG_PCT[0];
    rise_sel  = SEG_RISE[0];
    wide_next = 1'b1;
    for (int i = 1; i < SEGS; i++) begin
      if (mv >= SEG_LO[i]) begin
        lo_sel    = SEG_LO[i];
        base_next = SEG_PCT[i];
        rise_sel  = SEG_RISE[i];
        wide_next = 1'b0;
      end
    end
  end

  assign delta    = DELTA_W'(mv - lo_sel);
  assign div_m    = s1_wide ? DIV_M_300 : DIV_M_100;
  assign div_prod = (IPROD_W+DIV_M_W)'(s1_prod) * (IPROD_W+DIV_M_W)'(div_m);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= in_valid;
      out_valid <= s1_valid;
    end
    s1_mv   <= mv;
    s1_base <= base_next;
    s1_wide <= wide_next;
    s1_prod <= IPROD_W'(rise_sel) * IPROD_W'(delta);
    mv_out  <= s1_mv;
    pct     <= s1_base + PCT_W'(div_prod[DIV_SHIFT +: FRAC_W]);
  end

endmodule

### design/battery_voltage_to_percent_top.sv
// ----------------------------------------------------------------------------
// battery_voltage_to_percent_top
// Converts converter samples to battery millivolts, charge percent and flags.
// ----------------------------------------------------------------------------
// Usage: raise start with adc_sample for one cycle per request. busy is
// always low, so a request is taken in every cycle in which start is high.
// Each request gives one result: done pulses high for exactly one cycle with
// battery_mv, charge_percent, is_charging, is_low and is_critical valid.
// Throughput is one request per cycle. The six stages are the scale
// multiply, the reciprocal multiply, the remainder correction and clamp,
// the segment lookup with its small multiply, the span division by
// reciprocal, and the flag compares in the output register.
// The configuration port writes a register whenever wr_en is high; index 0
// is the charging threshold, 1 the low percent, 2 the critical percent, and
// index 3 is ignored. Write only while no request is in flight.
// Reset clears the pipeline valid bits and restores the register defaults
// (4100 mV, 15 percent, 5 percent). The receiver cannot stall the results.
// ----------------------------------------------------------------------------
module battery_voltage_to_percent_top import bvp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [SAMPLE_W-1:0] adc_sample,
  input  logic                wr_en,
  input  logic [INDEX_W-1:0]  wr_index,
  input  logic [MV_W-1:0]     wr_data,
  output logic                done,
  output logic [MV_W-1:0]     battery_mv,
  output logic [PCT_W-1:0]    charge_percent,
  output logic                is_charging,
  output logic                is_low,
  output logic                is_critical
);

  logic [MV_W-1:0]  charge_threshold_mv;
  logic [PCT_W-1:0] low_percent;
  logic [PCT_W-1:0] critical_percent;
  logic             mv_valid;
  logic [MV_W-1:0]  mv;
  logic             pct_valid;
  logic [MV_W-1:0]  pct_mv;
  logic [PCT_W-1:0] pct;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      charge_threshold_mv <= RESET_CHARGE_THRESHOLD;
      low_percent         <= RESET_LOW_PERCENT;
      critical_percent    <= RESET_CRITICAL_PERCENT;
    end else if (wr_en) begin
      case (wr_index)
        REG_CHARGE_THRESHOLD: charge_threshold_mv <= wr_data;
        REG_LOW_PERCENT:      low_percent         <= wr_data[PCT_W-1:0];
        REG_CRITICAL_PERCENT: critical_percent    <= wr_data[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  bvp_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .sample    (adc_sample),
    .out_valid (mv_valid),
    .mv        (mv)
  );

  bvp_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mv_valid),
    .mv        (mv),
    .out_valid (pct_valid),
    .mv_out    (pct_mv),
    .pct       (pct)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= pct_valid;
    end
    battery_mv     <= pct_mv;
    charge_percent <= pct;
    is_charging    <= pct_mv > charge_threshold_mv;
    is_low         <= pct <= low_percent;
    is_critical    <= pct <= critical_percent;
  end

endmodule
